@@ hdl/daily_rtc_periodic_wake_alarm_assert.svh @@
// Assertion macros used by the checker module of the RTC wake alarm block.
`ifndef DAILY_RTC_PERIODIC_WAKE_ALARM_ASSERT_SVH
`define DAILY_RTC_PERIODIC_WAKE_ALARM_ASSERT_SVH

// Antecedent true at an edge implies consequent at the same edge.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent true at an edge implies consequent at the next edge.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/drtc_pkg.sv @@
// Package of the RTC wake alarm block: function codes, item and state types, day wrap.
`timescale 1ns / 1ps

package drtc_pkg;

	localparam int DAY_TICKS = 86400;
	localparam int CNT_W = 17;
	localparam int SUM_W = CNT_W + 1;
	// number of whole days that can fit in a sum of two counter values
	localparam int DAY_MULTS = ((1 << SUM_W) - 1) / DAY_TICKS;

	localparam logic [CNT_W-1:0] DAY_LAST = CNT_W'(DAY_TICKS - 1);
	localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(86400);

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_SCHED = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef struct packed {
		logic [16:0] next_wake_time;
		logic [16:0] wake_period;
		logic        time_high_bit;
		logic [15:0] time_low;
	} item_t;

	typedef struct packed {
		logic        day_wrap_pulse;
		logic        wake_pulse;
		logic        now_high_bit;
		logic [15:0] now_low;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] alarm;
		logic [CNT_W-1:0] period;
	} state_t;

	// v mod DAY_TICKS by parallel compares against each multiple of the day
	function automatic logic [CNT_W-1:0] wrap_day(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = v;
		for (int k = 1; k <= DAY_MULTS; k++) begin
			if (32'(v) >= k * DAY_TICKS) begin
				r = v - SUM_W'(k * DAY_TICKS);
			end
		end
		return r[CNT_W-1:0];
	endfunction

endpackage

@@ hdl/drtc_step.sv @@
// Next-state and result logic for one item of the RTC wake alarm block.
`timescale 1ns / 1ps

module drtc_step (
	input  drtc_pkg::func_t   func,
	input  drtc_pkg::item_t   item,
	input  drtc_pkg::state_t  cur,
	output drtc_pkg::state_t  nxt,
	output drtc_pkg::result_t res
);

	logic [drtc_pkg::CNT_W-1:0] tick_count;
	logic                       tick_wrap;
	logic [drtc_pkg::CNT_W-1:0] set_time;
	logic [drtc_pkg::CNT_W-1:0] alarm_adv;
	logic [drtc_pkg::CNT_W-1:0] alarm_rearm;

	always_comb begin
		if (cur.count >= drtc_pkg::DAY_LAST) begin
			tick_count = '0;
			tick_wrap = 1'b1;
		end else begin
			tick_count = cur.count + 1'b1;
			tick_wrap = 1'b0;
		end
		set_time = {item.time_high_bit, item.time_low};
		if (set_time > drtc_pkg::DAY_LAST) begin
			set_time = drtc_pkg::DAY_LAST;
		end
	end

	assign alarm_adv   = drtc_pkg::wrap_day({1'b0, cur.alarm} + {1'b0, cur.period});
	assign alarm_rearm = drtc_pkg::wrap_day({1'b0, set_time} + {1'b0, cur.period});

	always_comb begin
		nxt = cur;
		res = '0;
		case (func)
			drtc_pkg::FUNC_TICK: begin
				nxt.count = tick_count;
				res.day_wrap_pulse = tick_wrap;
				// compare uses the counter after this tick's advance
				if (tick_count == cur.alarm) begin
					res.wake_pulse = 1'b1;
					nxt.alarm = alarm_adv;
				end
			end
			drtc_pkg::FUNC_SET: begin
				nxt.count = set_time;
				nxt.alarm = alarm_rearm;
			end
			drtc_pkg::FUNC_SCHED: begin
				nxt.period = item.wake_period;
				nxt.alarm = item.next_wake_time;
			end
			drtc_pkg::FUNC_READ: begin
				res.now_low = cur.count[15:0];
				res.now_high_bit = cur.count[16];
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

@@ hdl/daily_rtc_periodic_wake_alarm.sv @@
// Top level of the daily RTC counter with rescheduling wake alarm.
// Usage:
//   Slave channel s_*: one item per handshake. s_tuser carries the function
//   code (tick, set time, set schedule, read time); s_tdata carries the time
//   and schedule fields.
//   Master channel m_*: exactly one result item per input item, in order,
//   with the read-back time and the wake and day-wrap flags.
// Path: from input handshake to m_tvalid the item passes the input register, then
//   the result register; state updates when the item leaves the input register.
// Throughput: one item per cycle while results are taken, set by the single-pass
//   step logic between the input register and the result register.
// Stall: while m_tready is low the result holds; if the input register is empty,
//   one more item is taken into it, then s_tready drops until the result is taken.
// Reset: arst_n clears both pipeline valid flags, the counter and the alarm
//   to zero and the period to one day.
`timescale 1ns / 1ps

module daily_rtc_periodic_wake_alarm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] func
	input  logic [1:0]  s_tuser,
	// [15:0] time_low, [16] time_high_bit, [33:17] wake_period,
	// [50:34] next_wake_time, [55:51] zero
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] now_low, [16] now_high_bit, [17] wake_pulse, [18] day_wrap_pulse,
	// [23:19] zero
	output logic [23:0] m_tdata
);

	logic              valid_s1;
	drtc_pkg::func_t   func_s1;
	drtc_pkg::item_t   item_s1;
	drtc_pkg::state_t  state_q;
	drtc_pkg::state_t  state_nxt;
	drtc_pkg::result_t res_nxt;
	logic              out_valid_q;
	drtc_pkg::result_t out_res_q;
	logic              out_free;
	logic              advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	drtc_step u_step (
		.func (func_s1),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q.count <= '0;
			state_q.alarm <= '0;
			state_q.period <= drtc_pkg::PERIOD_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= drtc_pkg::func_t'(s_tuser);
			item_s1 <= s_tdata[50:0];
		end
		if (advance) begin
			out_res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_res_q};

endmodule

@@ hdl/drtc_checker.sv @@
// Port-level checker for the RTC wake alarm block, bound to the top level.
`timescale 1ns / 1ps
`include "daily_rtc_periodic_wake_alarm_assert.svh"

module drtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic in_acc;
	logic out_stall;
	logic has_now;
	logic no_flags;

	assign in_acc    = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;
	assign has_now   = m_tvalid && (m_tdata[16:0] != 17'd0);
	assign no_flags  = (m_tdata[18:17] == 2'b00);

	`ASSERT_NXT(a_stall_valid, clk, arst_n, out_stall, m_tvalid, "result dropped under stall")
	`ASSERT_NXT(a_stall_data, clk, arst_n, out_stall, $stable(m_tdata), "stalled result changed")
	// a read-back result never carries tick flags
	`ASSERT_IMP(a_read_no_flags, clk, arst_n, has_now, no_flags, "read result with tick flags")
	// a fresh result follows an accepted item, held in between by the input register
	`ASSERT_IMP(a_latency, clk, arst_n, $rose(m_tvalid), $past(in_acc, 2), "result without item")

endmodule

bind daily_rtc_periodic_wake_alarm drtc_checker u_drtc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
